// ===== hw/rtl/gmst_pkg.sv =====
// ----------------------------------------------------------------------------
// gmst_pkg
// Shared types, slot map, address letters and the G-word group match for the
// modal state tracker.
// ----------------------------------------------------------------------------
package gmst_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_SLOT_COUNT  = 42;
  localparam int SLOT_W          = 6;
  localparam int OP_DEPTH        = 2;
  localparam int OUT_DEPTH       = 4;

  localparam logic [SLOT_W-1:0] SLOT_G00 = 6'd0;
  localparam logic [SLOT_W-1:0] SLOT_G01 = 6'd1;
  localparam logic [SLOT_W-1:0] SLOT_G02 = 6'd2;
  localparam logic [SLOT_W-1:0] SLOT_G03 = 6'd3;
  localparam logic [SLOT_W-1:0] SLOT_G04 = 6'd4;
  localparam logic [SLOT_W-1:0] SLOT_G05 = 6'd5;
  localparam logic [SLOT_W-1:0] SLOT_G06 = 6'd6;
  localparam logic [SLOT_W-1:0] SLOT_G07 = 6'd7;
  localparam logic [SLOT_W-1:0] SLOT_G08 = 6'd8;
  localparam logic [SLOT_W-1:0] SLOT_G09 = 6'd9;
  localparam logic [SLOT_W-1:0] SLOT_G10 = 6'd10;
  localparam logic [SLOT_W-1:0] SLOT_G11 = 6'd11;
  localparam logic [SLOT_W-1:0] SLOT_G12 = 6'd12;
  localparam logic [SLOT_W-1:0] SLOT_G13 = 6'd13;
  localparam logic [SLOT_W-1:0] SLOT_G14 = 6'd14;
  localparam logic [SLOT_W-1:0] SLOT_G15 = 6'd15;
  localparam logic [SLOT_W-1:0] SLOT_G16 = 6'd16;
  localparam logic [SLOT_W-1:0] SLOT_G17 = 6'd17;
  localparam logic [SLOT_W-1:0] SLOT_G18 = 6'd18;
  localparam logic [SLOT_W-1:0] SLOT_G20 = 6'd19;
  localparam logic [SLOT_W-1:0] SLOT_G22 = 6'd20;
  localparam logic [SLOT_W-1:0] SLOT_G34 = 6'd21;
  localparam logic [SLOT_W-1:0] SLOT_M   = 6'd22;
  localparam logic [SLOT_W-1:0] SLOT_PG  = 6'd23;
  localparam logic [SLOT_W-1:0] SLOT_PX  = 6'd24;
  localparam logic [SLOT_W-1:0] SLOT_X   = 6'd25;
  localparam logic [SLOT_W-1:0] SLOT_Y   = 6'd26;
  localparam logic [SLOT_W-1:0] SLOT_Z   = 6'd27;
  localparam logic [SLOT_W-1:0] SLOT_I   = 6'd28;
  localparam logic [SLOT_W-1:0] SLOT_J   = 6'd29;
  localparam logic [SLOT_W-1:0] SLOT_K   = 6'd30;
  localparam logic [SLOT_W-1:0] SLOT_H   = 6'd31;
  localparam logic [SLOT_W-1:0] SLOT_P   = 6'd32;
  localparam logic [SLOT_W-1:0] SLOT_AR  = 6'd33;
  localparam logic [SLOT_W-1:0] SLOT_PR  = 6'd34;
  localparam logic [SLOT_W-1:0] SLOT_S   = 6'd35;
  localparam logic [SLOT_W-1:0] SLOT_F   = 6'd36;
  localparam logic [SLOT_W-1:0] SLOT_T   = 6'd37;
  localparam logic [SLOT_W-1:0] SLOT_D   = 6'd38;
  localparam logic [SLOT_W-1:0] SLOT_E   = 6'd39;
  localparam logic [SLOT_W-1:0] SLOT_L   = 6'd40;
  localparam logic [SLOT_W-1:0] SLOT_Q   = 6'd41;
  localparam logic [SLOT_W-1:0] NO_SLOT  = 6'd63;

  localparam logic [6:0] LTR_D = 7'd68;
  localparam logic [6:0] LTR_E = 7'd69;
  localparam logic [6:0] LTR_F = 7'd70;
  localparam logic [6:0] LTR_G = 7'd71;
  localparam logic [6:0] LTR_H = 7'd72;
  localparam logic [6:0] LTR_I = 7'd73;
  localparam logic [6:0] LTR_J = 7'd74;
  localparam logic [6:0] LTR_K = 7'd75;
  localparam logic [6:0] LTR_L = 7'd76;
  localparam logic [6:0] LTR_M = 7'd77;
  localparam logic [6:0] LTR_P = 7'd80;
  localparam logic [6:0] LTR_Q = 7'd81;
  localparam logic [6:0] LTR_R = 7'd82;
  localparam logic [6:0] LTR_S = 7'd83;
  localparam logic [6:0] LTR_T = 7'd84;
  localparam logic [6:0] LTR_X = 7'd88;
  localparam logic [6:0] LTR_Y = 7'd89;
  localparam logic [6:0] LTR_Z = 7'd90;

  localparam logic REQ_WORD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam longint G_DWELL     = 64'sd4000;
  localparam longint G_CYCLE_OFF = 64'sd80000;
  localparam longint M_CALL      = 64'sd98000;

  typedef struct packed {
    logic               req_type;
    logic [6:0]         word_letter;
    logic signed [31:0] word_value;
    logic               line_end;
    logic [SLOT_W-1:0]  read_slot;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic signed [31:0] slot_value;
    logic               format_error;
    logic               last_result;
  } out_word_t;

  // One classified word on its way from the front end to the back end.
  // cnt is the number of slots touched; zero means an ignored word.
  typedef struct packed {
    logic               is_read;
    logic [1:0]         cnt;
    logic [SLOT_W-1:0]  slot_a;
    logic [SLOT_W-1:0]  slot_b;
    logic signed [31:0] value;
    logic               err;
  } op_t;

  typedef struct packed {
    logic [1:0]        cnt;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
  } g_class_t;

  function automatic logic in_span(longint v, longint lo, longint hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Maps a G value to its modal group slot. G80.4 and G81.4 also touch
  // the synchronization group.
  function automatic g_class_t classify_g(longint v);
    g_class_t c;
    c.cnt = 2'd1;
    c.a   = NO_SLOT;
    c.b   = NO_SLOT;
    if (v == 0 || v == 1000 || v == 2000 || v == 3000 || v == 33000 ||
        v == 75000 || v == 77000 || v == 78000 || v == 79000) c.a = SLOT_G01;
    else if (v == 4000) c.a = SLOT_G00;
    else if (v == 15000 || v == 16000) c.a = SLOT_G17;
    else if (in_span(v, 17000, 19000)) c.a = SLOT_G02;
    else if (v == 20000 || v == 21000) c.a = SLOT_G06;
    else if (v == 22000 || v == 23000) c.a = SLOT_G04;
    else if (v == 40000 || v == 41000 || v == 42000) c.a = SLOT_G07;
    else if (v == 40100 || v == 41100 || v == 42100) c.a = SLOT_G18;
    else if (v == 43000 || v == 44000 || v == 49000) c.a = SLOT_G08;
    else if (v == 50000 || v == 51000) c.a = SLOT_G11;
    else if (v == 50100 || v == 51100) c.a = SLOT_G22;
    else if (in_span(v, 54000, 59000)) c.a = SLOT_G14;
    else if (in_span(v, 60000, 64000)) c.a = SLOT_G15;
    else if (v == 66000 || v == 67000) c.a = SLOT_G12;
    else if (v == 68000 || v == 69000) c.a = SLOT_G16;
    else if (v == 73000 || v == 74000 || v == 76000 || in_span(v, 80000, 89000)) begin
      c.a = SLOT_G09;
      if (v == 80400 || v == 81400) begin
        c.cnt = 2'd2;
        c.b   = SLOT_G34;
      end
    end
    else if (v == 90000 || v == 91000) c.a = SLOT_G03;
    else if (v == 93000 || v == 94000 || v == 95000) c.a = SLOT_G05;
    else if (v == 96000 || v == 97000) c.a = SLOT_G13;
    else if (v == 98000 || v == 99000) c.a = SLOT_G10;
    else if (v == 160000 || v == 161000) c.a = SLOT_G20;
    else c.cnt = 2'd0;
    return c;
  endfunction

  // Power-on contents of the modal table.
  function automatic logic signed [31:0] reset_value(logic [SLOT_W-1:0] slot);
    logic signed [31:0] r;
    case (slot)
      SLOT_G02: r = 32'sd17000;
      SLOT_G03: r = 32'sd90000;
      SLOT_G04: r = 32'sd22000;
      SLOT_G05: r = 32'sd94000;
      SLOT_G06: r = 32'sd21000;
      SLOT_G07: r = 32'sd40000;
      SLOT_G08: r = 32'sd49000;
      SLOT_G09: r = 32'sd80000;
      SLOT_G10: r = 32'sd98000;
      SLOT_G11: r = 32'sd50000;
      SLOT_G12: r = 32'sd67000;
      SLOT_G13: r = 32'sd97000;
      SLOT_G14: r = 32'sd54000;
      SLOT_G15: r = 32'sd64000;
      SLOT_G16: r = 32'sd69000;
      SLOT_G17: r = 32'sd15000;
      SLOT_G18: r = 32'sd40100;
      SLOT_G20: r = 32'sd160000;
      SLOT_G22: r = 32'sd50100;
      SLOT_G34: r = 32'sd80400;
      default:  r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gmst_ram.sv =====
// ----------------------------------------------------------------------------
// gmst_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 42,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gmst_queue.sv =====
// ----------------------------------------------------------------------------
// gmst_queue
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module gmst_queue #(
  parameter type T    = logic,
  parameter int DEPTH = 2,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  T              wdata,
  input  logic          pop,
  output T              rdata,
  output logic          empty,
  output logic          full,
  output logic [CW-1:0] count
);

  T              slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gmst_front.sv =====
// ----------------------------------------------------------------------------
// gmst_front
// Classifies each incoming word into the slots it touches and tracks the
// M98 call state and the two modal flags that steer X and R.
// ----------------------------------------------------------------------------
module gmst_front
  import gmst_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int SLOT_COUNT  = DEF_SLOT_COUNT
) (
  input  logic     clk,
  input  logic     rst,
  input  in_word_t item,
  input  logic     accept,
  output op_t      op
);

  logic call_pending;
  logic call_pending_next;
  logic dwell_active;
  logic dwell_active_next;
  logic cycle_off;
  logic cycle_off_next;

  logic signed [VALUE_WIDTH-1:0] wv;
  longint                        v;
  g_class_t                      gc;
  logic [SLOT_W-1:0]             plain;

  assign wv = VALUE_WIDTH'(item.word_value);
  assign v  = 64'(wv);
  assign gc = classify_g(v);

  always_comb begin
    case (item.word_letter)
      LTR_X:   plain = dwell_active ? SLOT_PX : SLOT_X;
      LTR_Y:   plain = SLOT_Y;
      LTR_Z:   plain = SLOT_Z;
      LTR_I:   plain = SLOT_I;
      LTR_J:   plain = SLOT_J;
      LTR_K:   plain = SLOT_K;
      LTR_H:   plain = SLOT_H;
      LTR_P:   plain = SLOT_P;
      LTR_R:   plain = cycle_off ? SLOT_AR : SLOT_PR;
      LTR_S:   plain = SLOT_S;
      LTR_F:   plain = SLOT_F;
      LTR_T:   plain = SLOT_T;
      LTR_D:   plain = SLOT_D;
      LTR_E:   plain = SLOT_E;
      LTR_L:   plain = SLOT_L;
      LTR_Q:   plain = SLOT_Q;
      LTR_M:   plain = SLOT_M;
      default: plain = NO_SLOT;
    endcase
  end

  always_comb begin
    op                = '0;
    op.value          = item.word_value;
    op.slot_a         = NO_SLOT;
    op.slot_b         = NO_SLOT;
    call_pending_next = call_pending;
    dwell_active_next = dwell_active;
    cycle_off_next    = cycle_off;

    if (item.req_type == REQ_READ) begin
      op.is_read = 1'b1;
      if (32'(item.read_slot) < 32'(SLOT_COUNT)) begin
        op.cnt    = 2'd1;
        op.slot_a = item.read_slot;
      end
    end else begin
      if (call_pending) begin
        call_pending_next = 1'b0;
        if (item.word_letter == LTR_P) begin
          op.cnt    = 2'd2;
          op.slot_a = SLOT_PG;
          op.slot_b = SLOT_P;
        end else begin
          op.err = 1'b1;
        end
      end

      if (op.cnt == 2'd0) begin
        if (item.word_letter == LTR_G) begin
          op.cnt    = gc.cnt;
          op.slot_a = gc.a;
          op.slot_b = gc.b;
        end else begin
          op.slot_a = plain;
          op.cnt    = (plain != NO_SLOT) ? 2'd1 : 2'd0;
          if (item.word_letter == LTR_M && v == M_CALL) begin
            call_pending_next = 1'b1;
          end
        end
      end

      // A call still open at the end of a line is dropped and flagged.
      if (item.line_end && call_pending_next) begin
        op.err            = 1'b1;
        call_pending_next = 1'b0;
      end

      // Only G words reach the group 00 and group 09 slots.
      if (op.cnt != 2'd0 && op.slot_a == SLOT_G00) begin
        dwell_active_next = (v == G_DWELL);
      end
      if (op.cnt != 2'd0 && op.slot_a == SLOT_G09) begin
        cycle_off_next = (v == G_CYCLE_OFF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      call_pending <= 1'b0;
      dwell_active <= 1'b0;
      cycle_off    <= 1'b1;
    end else if (accept) begin
      call_pending <= call_pending_next;
      dwell_active <= dwell_active_next;
      cycle_off    <= cycle_off_next;
    end
  end

endmodule

// ===== hw/rtl/gmst_back.sv =====
// ----------------------------------------------------------------------------
// gmst_back
// Carries out classified words against the modal table, one slot per cycle
// while the result queue has room, and hands each result to that queue.
// ----------------------------------------------------------------------------
module gmst_back
  import gmst_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
  localparam int AW         = $clog2(SLOT_COUNT),
  localparam int OCW        = $clog2(OUT_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  op_t            op,
  input  logic           op_empty,
  output logic           op_pop,
  input  logic [OCW-1:0] out_count,
  output logic           out_push,
  output out_word_t      out_word
);

  logic                  phase;
  logic                  phase_next;
  logic [SLOT_COUNT-1:0] valid;

  logic                  s1_valid;
  logic [SLOT_W-1:0]     s1_slot;
  logic signed [31:0]    s1_value;
  logic                  s1_err;
  logic                  s1_last;
  logic                  s1_use_ram;

  logic                          issue;
  logic                          can_issue;
  logic                          none;
  logic                          last;
  logic [SLOT_W-1:0]             cur_slot;
  logic [AW-1:0]                 idx;
  logic signed [VALUE_WIDTH-1:0] wv;
  logic                          ram_we;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] ram_value;

  // Room is counted against the staged result as well as the queue.
  assign can_issue = (OCW'(out_count) + OCW'(s1_valid)) < OCW'(OUT_DEPTH);
  assign issue     = !op_empty && can_issue;
  assign none      = (op.cnt == 2'd0);
  assign last      = (op.cnt != 2'd2) || phase;
  assign cur_slot  = phase ? op.slot_b : op.slot_a;
  assign idx       = AW'(cur_slot);
  assign wv        = VALUE_WIDTH'(op.value);
  assign ram_we    = issue && !op.is_read && !none;
  assign op_pop    = issue && last;
  assign phase_next = issue ? !last : phase;

  gmst_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (wv),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign ram_value = ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 1'b0;
      valid    <= '0;
      s1_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      s1_valid <= issue;
      if (ram_we) begin
        valid[idx] <= 1'b1;
      end
    end
  end

  // A slot never written since reset reads as its power-on value.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_slot    <= none ? NO_SLOT : cur_slot;
      s1_err     <= op.err;
      s1_last    <= last;
      s1_use_ram <= op.is_read && !none && valid[idx];
      if (none) begin
        s1_value <= 32'sd0;
      end else if (op.is_read) begin
        s1_value <= reset_value(cur_slot);
      end else begin
        s1_value <= 32'(wv);
      end
    end
  end

  assign out_push              = s1_valid;
  assign out_word.slot_index   = s1_slot;
  assign out_word.slot_value   = s1_use_ram ? 32'(ram_value) : s1_value;
  assign out_word.format_error = s1_err;
  assign out_word.last_result  = s1_last;

endmodule

// ===== hw/rtl/gcode_modal_state_tracker.sv =====
// ----------------------------------------------------------------------------
// gcode_modal_state_tracker
// Tracks the modal state of a G-code program one word at a time and answers
// reads of single modal slots.
//
//   Channel   Handshake          Payload     Meaning
//   input     push / full        item        program word or slot read
//   result    empty / pop        result      slot written or read, one or two
//
// One word is accepted per cycle while full is low. A word touches at most one
// table slot per cycle in the back end, which has a single write port on the
// table RAM, so G80.4, G81.4 and P after M98 handle their two slots in turn.
// A word waits in the op queue, its results in the back-end result stage.
// Reset clears the queues, the per-slot valid bits and the call state; the
// table reads its power-on values at once, with no clearing pass.
// full rises when the two-word queue between front and back end holds two
// words; the back end stops issuing when the four-word result queue has no room.
// ----------------------------------------------------------------------------
module gcode_modal_state_tracker
  import gmst_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int SLOT_COUNT  = DEF_SLOT_COUNT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  item,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic           accept;
  op_t            op_in;
  op_t            op_head;
  logic           op_empty;
  logic           op_pop;
  logic           out_push;
  logic           out_full;
  out_word_t      out_word;
  logic [OCW-1:0] out_count;

  assign accept = push && !full;

  gmst_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .accept (accept),
    .op     (op_in)
  );

  gmst_queue #(
    .T     (op_t),
    .DEPTH (OP_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_in),
    .pop   (op_pop),
    .rdata (op_head),
    .empty (op_empty),
    .full  (full),
    .count ()
  );

  gmst_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (op_head),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_word  (out_word)
  );

  gmst_queue #(
    .T     (out_word_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_word),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  // The back end must never hand a result to a full result queue.
  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    !(out_push && out_full))
    else $error("result queue overflow");

  // The back end only retires a word that is really queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !op_empty)
    else $error("op queue popped while empty");

  // An ignored word always reports a zero value.
  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.slot_index == NO_SLOT) |-> (result.slot_value == 32'sd0))
    else $error("ignored word with nonzero value");

  // The first result of a two-slot word always names a real slot.
  a_two_slot_order: assert property (@(posedge clk) disable iff (rst)
    (out_push && !out_word.last_result) |-> (out_word.slot_index != NO_SLOT))
    else $error("first result of a two-slot word has no slot");

endmodule
